FILE: hdl/cpm_pkg.sv
// cpm_pkg: shared types and constants for the colour primaries matrix unit.
// Used by cpm_front, cpm_lane and color_primaries_matrix_unit.
// No dependencies.
`timescale 1ns / 1ps

package cpm_pkg;

    // operation codes (s_tuser)
    localparam logic [1:0] OP_SCALES  = 2'd0;
    localparam logic [1:0] OP_RGB2XYZ = 2'd1;
    localparam logic [1:0] OP_XYZ2RGB = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam int IN_W   = 16;              // chromaticity / scale width
    localparam int P_W    = 18;              // signed x, y, z
    localparam int PM_W   = 17;              // |x|, |y|, |z|
    localparam int ADJ_W  = 35;              // signed adjugate entry
    localparam int AM_W   = 34;              // |adjugate entry|
    localparam int DET_W  = 53;              // signed determinant, signed numerators
    localparam int MAG_W  = 52;              // magnitudes of the above
    localparam int BASE_W = IN_W + MAG_W;    // numerator before fixed-point shift
    localparam int DEN_W  = IN_W + MAG_W;    // divisor
    localparam int PY_W   = 3 * IN_W;        // product of three y or three scales
    localparam int COL_W  = 25;              // output column width
    localparam int QBITS  = 26;              // quotient bits before rounding
    localparam int DIV_LAT = QBITS + 2;      // lane latency in cycles

    localparam logic signed [P_W-1:0] ONE_P = 18'sd65536;

    localparam logic [QBITS:0] Q_SAT  = 27'd67108864;  // quotient clamp 2^26
    localparam logic [QBITS:0] NEG_LIM = 27'd16777216; // 2^24
    localparam logic [QBITS:0] POS_LIM = 27'd16777215; // 2^24 - 1

    // one input transfer, unpacked into fields
    typedef struct packed {
        logic [1:0]                op;
        logic [2:0][IN_W-1:0]      x;
        logic [2:0][IN_W-1:0]      y;
        logic [IN_W-1:0]           wx;
        logic [IN_W-1:0]           wy;
        logic [2:0][IN_W-1:0]      sc;
    } req_t;

    // item ready for row issue: operands for lane r, row k at [r][k]
    typedef struct packed {
        logic [1:0]                   op;
        logic                         err;
        logic [2:0][2:0][BASE_W-1:0]  base;
        logic [2:0][2:0][DEN_W-1:0]   den;
        logic [2:0][2:0]              neg;
    } item_t;

    // sideband that travels beside the lanes
    typedef struct packed {
        logic       valid;
        logic [1:0] row;
        logic       last;
        logic       err;
    } tag_t;

endpackage

FILE: hdl/cpm_front.sv
// cpm_front: four-stage set-up of adjugate, determinant, numerators, divisors
// and error checks for one request. Depends on cpm_pkg.
`timescale 1ns / 1ps

module cpm_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            req_valid,
    input  cpm_pkg::req_t   req,
    output logic            item_valid,
    output cpm_pkg::item_t  item
);

    localparam int P_W    = cpm_pkg::P_W;
    localparam int ADJ_W  = cpm_pkg::ADJ_W;
    localparam int DET_W  = cpm_pkg::DET_W;
    localparam int MAG_W  = cpm_pkg::MAG_W;
    localparam int AM_W   = cpm_pkg::AM_W;
    localparam int PM_W   = cpm_pkg::PM_W;
    localparam int IN_W   = cpm_pkg::IN_W;
    localparam int PY_W   = cpm_pkg::PY_W;
    localparam int BASE_W = cpm_pkg::BASE_W;
    localparam int DEN_W  = cpm_pkg::DEN_W;
    localparam int HALF_W = PY_W / 2;
    localparam int PL_W   = MAG_W + HALF_W;
    localparam int LHS_W  = MAG_W + PY_W;

    localparam logic signed [P_W-1:0] ONE_P_C = cpm_pkg::ONE_P;

    function automatic logic signed [ADJ_W-1:0] cross2(
        input logic signed [P_W-1:0] a,
        input logic signed [P_W-1:0] b,
        input logic signed [P_W-1:0] c,
        input logic signed [P_W-1:0] d);
        logic signed [2*P_W-1:0] t;
        t = a * b - c * d;
        return t[ADJ_W-1:0];
    endfunction

    function automatic logic [MAG_W-1:0] mag_det(input logic signed [DET_W-1:0] v);
        logic [DET_W-1:0] t;
        t = v[DET_W-1] ? -v : v;
        return t[MAG_W-1:0];
    endfunction

    function automatic logic [AM_W-1:0] mag_adj(input logic signed [ADJ_W-1:0] v);
        logic [ADJ_W-1:0] t;
        t = v[ADJ_W-1] ? -v : v;
        return t[AM_W-1:0];
    endfunction

    function automatic logic [PM_W-1:0] mag_p(input logic signed [P_W-1:0] v);
        logic [P_W-1:0] t;
        t = v[P_W-1] ? -v : v;
        return t[PM_W-1:0];
    endfunction

    // ---------------- stage 1: primary matrix and adjugate
    logic signed [P_W-1:0]        p_c   [0:2][0:2];
    logic signed [ADJ_W-1:0]      adj_c [0:2][0:2];

    logic                         v1_reg;
    logic [1:0]                   op1_reg;
    logic signed [P_W-1:0]        p1_reg   [0:2][0:2];
    logic signed [ADJ_W-1:0]      adj1_reg [0:2][0:2];
    logic [2*IN_W-1:0]            y01_reg, sc01_reg;
    logic [2:0][IN_W-1:0]         y1_reg, sc1_reg;
    logic [IN_W-1:0]              wx1_reg, wy1_reg;
    logic                         yz1_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            p_c[0][k] = $signed({2'b00, req.x[k]});
            p_c[1][k] = $signed({2'b00, req.y[k]});
            p_c[2][k] = ONE_P_C - p_c[0][k] - p_c[1][k];
        end
        adj_c[0][0] = cross2(p_c[1][1], p_c[2][2], p_c[1][2], p_c[2][1]);
        adj_c[0][1] = cross2(p_c[0][2], p_c[2][1], p_c[0][1], p_c[2][2]);
        adj_c[0][2] = cross2(p_c[0][1], p_c[1][2], p_c[0][2], p_c[1][1]);
        adj_c[1][0] = cross2(p_c[1][2], p_c[2][0], p_c[1][0], p_c[2][2]);
        adj_c[1][1] = cross2(p_c[0][0], p_c[2][2], p_c[0][2], p_c[2][0]);
        adj_c[1][2] = cross2(p_c[0][2], p_c[1][0], p_c[0][0], p_c[1][2]);
        adj_c[2][0] = cross2(p_c[1][0], p_c[2][1], p_c[1][1], p_c[2][0]);
        adj_c[2][1] = cross2(p_c[0][1], p_c[2][0], p_c[0][0], p_c[2][1]);
        adj_c[2][2] = cross2(p_c[0][0], p_c[1][1], p_c[0][1], p_c[1][0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op1_reg  <= req.op;
            p1_reg   <= p_c;
            adj1_reg <= adj_c;
            y01_reg  <= req.y[0] * req.y[1];
            sc01_reg <= req.sc[0] * req.sc[1];
            y1_reg   <= req.y;
            sc1_reg  <= req.sc;
            wx1_reg  <= req.wx;
            wy1_reg  <= req.wy;
            yz1_reg  <= (req.y[0] == '0) || (req.y[1] == '0) || (req.y[2] == '0);
        end
    end

    // ---------------- stage 2: determinant, white numerators, magnitudes
    logic signed [DET_W-1:0]      det_c;
    logic signed [DET_W-1:0]      n_c [0:2];
    logic signed [P_W-1:0]        pw_c [0:2];

    logic                         v2_reg;
    logic [1:0]                   op2_reg;
    logic [MAG_W-1:0]             detm2_reg;
    logic                         detn2_reg;
    logic [2:0][MAG_W-1:0]        nm2_reg;
    logic [2:0]                   nn2_reg;
    logic [2:0][2:0][AM_W-1:0]    am2_reg;
    logic [2:0][2:0]              an2_reg;
    logic [2:0][2:0][PM_W-1:0]    pm2_reg;
    logic [2:0][2:0]              pn2_reg;
    logic [PY_W-1:0]              py2_reg, psc2_reg;
    logic [2:0][IN_W-1:0]         y2_reg, sc2_reg;
    logic [IN_W-1:0]              wy2_reg;
    logic                         yz2_reg, wz2_reg;

    always_comb
    begin
        pw_c[0] = $signed({2'b00, wx1_reg});
        pw_c[1] = $signed({2'b00, wy1_reg});
        pw_c[2] = ONE_P_C - pw_c[0] - pw_c[1];
        det_c = p1_reg[0][0] * adj1_reg[0][0] + p1_reg[0][1] * adj1_reg[1][0]
              + p1_reg[0][2] * adj1_reg[2][0];
        for (int r = 0; r < 3; r++)
        begin
            n_c[r] = adj1_reg[r][0] * pw_c[0] + adj1_reg[r][1] * pw_c[1]
                   + adj1_reg[r][2] * pw_c[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (adv)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op2_reg   <= op1_reg;
            detm2_reg <= mag_det(det_c);
            detn2_reg <= det_c[DET_W-1];
            for (int r = 0; r < 3; r++)
            begin
                nm2_reg[r] <= mag_det(n_c[r]);
                nn2_reg[r] <= n_c[r][DET_W-1];
                for (int k = 0; k < 3; k++)
                begin
                    am2_reg[r][k] <= mag_adj(adj1_reg[r][k]);
                    an2_reg[r][k] <= adj1_reg[r][k][ADJ_W-1];
                    pm2_reg[r][k] <= mag_p(p1_reg[r][k]);
                    pn2_reg[r][k] <= p1_reg[r][k][P_W-1];
                end
            end
            py2_reg  <= y01_reg * y1_reg[2];
            psc2_reg <= sc01_reg * sc1_reg[2];
            y2_reg   <= y1_reg;
            sc2_reg  <= sc1_reg;
            wy2_reg  <= wy1_reg;
            yz2_reg  <= yz1_reg;
            wz2_reg  <= (wy1_reg == '0);
        end
    end

    // ---------------- stage 3: per-op numerators and divisors, white check
    logic [IN_W-1:0]              a_sel [0:2][0:2];
    logic [MAG_W-1:0]             b_sel [0:2][0:2];
    logic [IN_W-1:0]              d_sel [0:2];
    logic                         sing0_c;

    logic                         v3_reg;
    logic [1:0]                   op3_reg;
    logic                         err3_reg;
    logic [2:0][2:0][BASE_W-1:0]  base3_reg;
    logic [2:0][2:0][DEN_W-1:0]   den3_reg;
    logic [2:0][2:0]              neg3_reg;
    logic [PL_W-1:0]              pl3_reg, ph3_reg;
    logic [PY_W-1:0]              py3_reg;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            d_sel[r] = (op2_reg == cpm_pkg::OP_SCALES) ? wy2_reg : sc2_reg[r];
            for (int k = 0; k < 3; k++)
            begin
                a_sel[r][k] = (op2_reg == cpm_pkg::OP_RGB2XYZ) ? sc2_reg[k] : y2_reg[r];
                unique case (op2_reg)
                    cpm_pkg::OP_SCALES:  b_sel[r][k] = nm2_reg[r];
                    cpm_pkg::OP_RGB2XYZ: b_sel[r][k] = MAG_W'(pm2_reg[r][k]);
                    default:             b_sel[r][k] = MAG_W'(am2_reg[r][k]);
                endcase
            end
        end
        // |det(F)| below 2^-42 with det(F) = det / prod(y)
        sing0_c = (detm2_reg < MAG_W'(64)) && ({detm2_reg[5:0], 42'b0} < py2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op3_reg  <= op2_reg;
            err3_reg <= (op2_reg == cpm_pkg::OP_NONE) || yz2_reg
                     || ((op2_reg == cpm_pkg::OP_SCALES) && (wz2_reg || sing0_c));
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    base3_reg[r][k] <= a_sel[r][k] * b_sel[r][k];
                    if (op2_reg == cpm_pkg::OP_RGB2XYZ)
                    begin
                        den3_reg[r][k] <= DEN_W'({y2_reg[k], 16'b0});
                    end
                    else
                    begin
                        den3_reg[r][k] <= d_sel[r] * detm2_reg;
                    end
                    unique case (op2_reg)
                        cpm_pkg::OP_SCALES:  neg3_reg[r][k] <= nn2_reg[r] ^ detn2_reg;
                        cpm_pkg::OP_RGB2XYZ: neg3_reg[r][k] <= pn2_reg[r][k];
                        default:             neg3_reg[r][k] <= an2_reg[r][k] ^ detn2_reg;
                    endcase
                end
            end
            pl3_reg <= detm2_reg * psc2_reg[HALF_W-1:0];
            ph3_reg <= detm2_reg * psc2_reg[PY_W-1:HALF_W];
            py3_reg <= py2_reg;
        end
    end

    // ---------------- stage 4: inverse-matrix singular check
    logic [LHS_W-1:0] lhs_c;
    logic             sing2_c;

    logic             v4_reg;
    cpm_pkg::item_t   item4_reg;

    always_comb
    begin
        // det(M) = det * prod(scale) / (2^48 * prod(y))
        lhs_c   = LHS_W'(pl3_reg) + (LHS_W'(ph3_reg) << HALF_W);
        sing2_c = lhs_c < (LHS_W'(py3_reg) << 6);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item4_reg.op   <= op3_reg;
            item4_reg.err  <= err3_reg || ((op3_reg == cpm_pkg::OP_XYZ2RGB) && sing2_c);
            item4_reg.base <= base3_reg;
            item4_reg.den  <= den3_reg;
            item4_reg.neg  <= neg3_reg;
        end
    end

    assign item_valid = v4_reg;
    assign item       = item4_reg;

endmodule

FILE: hdl/cpm_lane.sv
// cpm_lane: pipelined restoring divider, one quotient bit per stage, with
// rounding (ties away from zero), sign and 25-bit saturation. Depends on cpm_pkg.
`timescale 1ns / 1ps

module cpm_lane
#(
    parameter int NUM_W = 100,
    parameter int DEN_W = 68
)
(
    input  logic                             clk,
    input  logic                             en,
    input  logic [NUM_W-1:0]                 num,
    input  logic [DEN_W-1:0]                 den,
    input  logic                             neg,
    output logic [cpm_pkg::COL_W-1:0]        col
);

    localparam int QBITS = cpm_pkg::QBITS;
    localparam int COL_W = cpm_pkg::COL_W;
    localparam int CW    = (NUM_W > DEN_W + QBITS + 1) ? NUM_W : DEN_W + QBITS + 1;

    logic [CW-1:0]     rem_reg [0:QBITS];
    logic [CW-1:0]     den_reg [0:QBITS];
    logic [QBITS-1:0]  q_reg   [0:QBITS];
    logic              neg_reg [0:QBITS];
    logic              sat_reg [0:QBITS];
    logic              dz_reg  [0:QBITS];
    logic [COL_W-1:0]  col_reg;

    // entry: clamp check and zero divisor
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= CW'(num);
            den_reg[0] <= CW'(den);
            q_reg[0]   <= '0;
            neg_reg[0] <= neg;
            sat_reg[0] <= CW'(num) >= (CW'(den) << QBITS);
            dz_reg[0]  <= (den == '0);
        end
    end

    // one quotient bit per stage, most significant first
    for (genvar i = 1; i <= QBITS; i++)
    begin : g_bit
        localparam int K = QBITS - i;
        logic [CW-1:0] dsh;
        logic          take;

        assign dsh  = den_reg[i-1] << K;
        assign take = rem_reg[i-1] >= dsh;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= take ? rem_reg[i-1] - dsh : rem_reg[i-1];
                q_reg[i]   <= q_reg[i-1] | (take ? (QBITS'(1) << K) : '0);
                den_reg[i] <= den_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
                sat_reg[i] <= sat_reg[i-1];
                dz_reg[i]  <= dz_reg[i-1];
            end
        end
    end

    // round, clamp, apply sign
    logic [QBITS:0]  qr;
    logic [QBITS:0]  qm;
    logic            rnd;
    logic [QBITS:0]  qneg;

    always_comb
    begin
        rnd = {rem_reg[QBITS], 1'b0} >= {1'b0, den_reg[QBITS]};
        qr  = sat_reg[QBITS] ? cpm_pkg::Q_SAT
                             : ({1'b0, q_reg[QBITS]} + (QBITS + 1)'(rnd));
        if (neg_reg[QBITS])
        begin
            qm = (qr > cpm_pkg::NEG_LIM) ? cpm_pkg::NEG_LIM : qr;
        end
        else
        begin
            qm = (qr > cpm_pkg::POS_LIM) ? cpm_pkg::POS_LIM : qr;
        end
        qneg = -qm;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dz_reg[QBITS])
            begin
                col_reg <= '0;
            end
            else if (neg_reg[QBITS])
            begin
                col_reg <= qneg[COL_W-1:0];
            end
            else
            begin
                col_reg <= qm[COL_W-1:0];
            end
        end
    end

    assign col = col_reg;

endmodule

FILE: hdl/color_primaries_matrix_unit.sv
// color_primaries_matrix_unit: top level. Set-up front, row issue, three
// divider lanes (one per matrix row element) and the merging output register.
// Depends on cpm_pkg, cpm_front, cpm_lane.
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser=op, tdata=11 x 16-bit fields
//  m_*      out  m_tvalid/m_tready  tdata=col0..2,row_index, tlast, tuser=error
//
// Ops 1 and 2 give three row transfers, one per cycle unless stalled; op 0
// and 3 give one. Sustained rate unless stalled: one request per cycle for
// ops 0 and 3, while ops 1 and 2 hold the input until their last row issues,
// set by the row issue stage. A request passes set-up, issue, lanes, output.
// Reset clears valid bits, issue row and sideband line; no clearing pass.
// A stall on m_tready freezes the whole pipe; the output register holds.
`timescale 1ns / 1ps

module color_primaries_matrix_unit
#(
    parameter int FRAC_BITS = 16
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [175:0]  s_tdata,   // red_x, green_x, blue_x, red_y, green_y,
                                     // blue_y, white_x, white_y, red_scale,
                                     // green_scale, blue_scale
    input  logic [1:0]    s_tuser,   // op
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [79:0]   m_tdata,   // col0, col1, col2, row_index, zero pad
    output logic          m_tlast,   // last_row
    output logic          m_tuser    // error_flag
);

    localparam int BASE_W  = cpm_pkg::BASE_W;
    localparam int DEN_W   = cpm_pkg::DEN_W;
    localparam int COL_W   = cpm_pkg::COL_W;
    localparam int IN_W    = cpm_pkg::IN_W;
    localparam int NUM_W   = BASE_W + IN_W + FRAC_BITS;
    localparam int DIV_LAT = cpm_pkg::DIV_LAT;

    logic en;
    logic adv;

    // unpack request
    cpm_pkg::req_t req;

    always_comb
    begin
        req.op = s_tuser;
        for (int k = 0; k < 3; k++)
        begin
            req.x[k]  = s_tdata[IN_W*k +: IN_W];
            req.y[k]  = s_tdata[IN_W*(3+k) +: IN_W];
            req.sc[k] = s_tdata[IN_W*(8+k) +: IN_W];
        end
        req.wx = s_tdata[IN_W*6 +: IN_W];
        req.wy = s_tdata[IN_W*7 +: IN_W];
    end

    // set-up front
    logic            front_valid;
    cpm_pkg::item_t  front_item;

    cpm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .req_valid  (s_tvalid),
        .req        (req),
        .item_valid (front_valid),
        .item       (front_item)
    );

    // row issue
    logic            iss_valid_reg, iss_valid_next;
    logic [1:0]      iss_row_reg, iss_row_next;
    cpm_pkg::item_t  iss_item_reg;
    logic            iss_single;
    logic            iss_final;

    assign en         = !m_tvalid || m_tready;
    assign iss_single = (iss_item_reg.op == cpm_pkg::OP_SCALES)
                     || (iss_item_reg.op == cpm_pkg::OP_NONE);
    assign iss_final  = iss_single || (iss_row_reg == 2'd2);
    assign adv        = en && (!iss_valid_reg || iss_final);
    assign s_tready   = adv;

    always_comb
    begin
        iss_valid_next = iss_valid_reg;
        iss_row_next   = iss_row_reg;
        if (adv)
        begin
            iss_valid_next = front_valid;
            iss_row_next   = 2'd0;
        end
        else if (en && iss_valid_reg)
        begin
            iss_row_next = iss_row_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_valid_reg <= 1'b0;
            iss_row_reg   <= 2'd0;
        end
        else
        begin
            iss_valid_reg <= iss_valid_next;
            iss_row_reg   <= iss_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            iss_item_reg <= front_item;
        end
    end

    // lanes: lane r produces element r of the current row
    logic [2:0][COL_W-1:0] lane_col;

    for (genvar r = 0; r < 3; r++)
    begin : g_lane
        logic [NUM_W-1:0] num;
        logic [BASE_W-1:0] b;

        assign b   = iss_item_reg.base[r][iss_row_reg];
        assign num = (iss_item_reg.op == cpm_pkg::OP_XYZ2RGB)
                   ? (NUM_W'(b) << (IN_W + FRAC_BITS))
                   : (NUM_W'(b) << FRAC_BITS);

        cpm_lane #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_lane
        (
            .clk (clk),
            .en  (en),
            .num (num),
            .den (iss_item_reg.den[r][iss_row_reg]),
            .neg (iss_item_reg.neg[r][iss_row_reg]),
            .col (lane_col[r])
        );
    end

    // sideband line matching lane latency
    cpm_pkg::tag_t tag_reg [0:DIV_LAT-1];
    cpm_pkg::tag_t tag_in;

    always_comb
    begin
        tag_in.valid = iss_valid_reg;
        tag_in.row   = iss_row_reg;
        tag_in.last  = iss_final;
        tag_in.err   = iss_item_reg.err;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIV_LAT; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[0] <= tag_in;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    // merge lanes and sideband into the output register
    logic                   out_valid_reg;
    logic [2:0][COL_W-1:0]  out_col_reg;
    logic [1:0]             out_row_reg;
    logic                   out_last_reg;
    logic                   out_err_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= tag_reg[DIV_LAT-1].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_col_reg  <= tag_reg[DIV_LAT-1].err ? '0 : lane_col;
            out_row_reg  <= tag_reg[DIV_LAT-1].row;
            out_last_reg <= tag_reg[DIV_LAT-1].last;
            out_err_reg  <= tag_reg[DIV_LAT-1].err;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_row_reg, out_col_reg[2], out_col_reg[1], out_col_reg[0]};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_err_reg;

    // an error row carries zero columns
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> (m_tdata[74:0] == '0))
    else $error("error row with non-zero columns");

    // row index 3 never leaves the block
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[76:75] != 2'd3))
    else $error("row index out of range");

    // only a finished issue lets a new request in
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (!iss_valid_reg || iss_final))
    else $error("request taken while rows still to issue");

    // a row that is not marked last is never row index 2
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |-> (m_tdata[76:75] != 2'd2))
    else $error("third row not marked last");

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for color_primaries_matrix_unit.
// Depends on cpm_pkg and the RTL top level. Directed and random requests are
// checked against an exact fixed-point predictor of the scales and matrices.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT = 60000;
    localparam int DRAIN_CYCLES = 60;   // longer than the input-to-output latency
    localparam int N_RANDOM = 155;

    typedef struct {
        logic [1:0]   op;
        logic [175:0] data;
        int           gap;
    } request_t;

    typedef struct {
        logic [24:0] col0;
        logic [24:0] col1;
        logic [24:0] col2;
        logic [1:0]  row;
        logic        last;
        logic        err;
    } row_result_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [175:0] s_tdata = '0;   // red_x, green_x, blue_x, red_y, green_y, blue_y,
                                  // white_x, white_y, red_scale, green_scale, blue_scale
    logic [1:0]   s_tuser = '0;   // op
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [79:0]  m_tdata;        // col0, col1, col2, row_index, zero pad
    logic         m_tlast;        // last_row
    logic         m_tuser;        // error_flag

    request_t    pending_reqs[$];
    row_result_t expected_rows[$];
    int          errors = 0;
    int          n_accepted = 0;
    int          n_rows = 0;
    int          n_err_rows = 0;
    int          cycles = 0;
    int          send_wait = 0;
    int          recv_wait = 0;

    color_primaries_matrix_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint unsigned abs64(longint v);
        return (v < 0) ? longint'(0) - v : v;
    endfunction

    // quotient rounded to nearest, ties away from zero, saturated to 25 bits
    function automatic logic [24:0] fixed_quotient(bit neg, logic [127:0] num,
                                                   logic [127:0] den);
        logic [127:0] q;
        logic [127:0] r;
        if (den == 0)
            return '0;
        if (num >= (den << 26))
            q = 128'd1 << 26;
        else
        begin
            q = num / den;
            r = num - q * den;
            if ((r << 1) >= den)
                q = q + 1;
        end
        if (neg)
        begin
            if (q > 128'd16777216)
                q = 128'd16777216;
            q = 128'd0 - q;
            return q[24:0];
        end
        if (q > 128'd16777215)
            q = 128'd16777215;
        return q[24:0];
    endfunction

    function automatic void push_row(logic [24:0] c0, logic [24:0] c1, logic [24:0] c2,
                                     int row, bit last, bit err);
        row_result_t e;
        e.col0 = c0;
        e.col1 = c1;
        e.col2 = c2;
        e.row  = row[1:0];
        e.last = last;
        e.err  = err;
        expected_rows.push_back(e);
    endfunction

    // expected rows for one accepted request
    function automatic void predict_matrix_rows(logic [1:0] op, logic [175:0] d);
        longint          p[3][3];
        longint          adj[3][3];
        longint          det;
        longint          n;
        longint          pw[3];
        longint unsigned ys[3];
        longint unsigned sc[3];
        longint unsigned wx;
        longint unsigned wy;
        longint unsigned prod_y;
        logic [127:0]    num;
        logic [127:0]    den;
        logic [127:0]    lhs;
        logic [24:0]     c[3];
        bit              y_zero;
        bit              bad;
        for (int k = 0; k < 3; k++)
        begin
            p[0][k] = d[16*k +: 16];
            p[1][k] = d[16*(3+k) +: 16];
            p[2][k] = 65536 - p[0][k] - p[1][k];
            ys[k] = d[16*(3+k) +: 16];
            sc[k] = d[16*(8+k) +: 16];
        end
        wx = d[16*6 +: 16];
        wy = d[16*7 +: 16];
        y_zero = (ys[0] == 0) || (ys[1] == 0) || (ys[2] == 0);
        prod_y = ys[0] * ys[1] * ys[2];

        adj[0][0] = p[1][1] * p[2][2] - p[1][2] * p[2][1];
        adj[0][1] = p[0][2] * p[2][1] - p[0][1] * p[2][2];
        adj[0][2] = p[0][1] * p[1][2] - p[0][2] * p[1][1];
        adj[1][0] = p[1][2] * p[2][0] - p[1][0] * p[2][2];
        adj[1][1] = p[0][0] * p[2][2] - p[0][2] * p[2][0];
        adj[1][2] = p[0][2] * p[1][0] - p[0][0] * p[1][2];
        adj[2][0] = p[1][0] * p[2][1] - p[1][1] * p[2][0];
        adj[2][1] = p[0][1] * p[2][0] - p[0][0] * p[2][1];
        adj[2][2] = p[0][0] * p[1][1] - p[0][1] * p[1][0];
        det = p[0][0] * adj[0][0] + p[0][1] * adj[1][0] + p[0][2] * adj[2][0];

        unique case (op)
            cpm_pkg::OP_SCALES:
            begin
                bad = y_zero || (wy == 0);
                if (!bad)
                begin
                    // |det(F)| below 2^-42 counts as singular
                    lhs = abs64(det);
                    lhs = lhs << 42;
                    if (lhs < prod_y)
                        bad = 1'b1;
                end
                if (bad)
                    push_row('0, '0, '0, 0, 1'b1, 1'b1);
                else
                begin
                    pw[0] = wx;
                    pw[1] = wy;
                    pw[2] = 65536 - pw[0] - pw[1];
                    for (int r = 0; r < 3; r++)
                    begin
                        n = adj[r][0] * pw[0] + adj[r][1] * pw[1] + adj[r][2] * pw[2];
                        num = ys[r];
                        num = (num * abs64(n)) << 16;
                        den = wy;
                        den = den * abs64(det);
                        c[r] = fixed_quotient((n < 0) != (det < 0), num, den);
                    end
                    push_row(c[0], c[1], c[2], 0, 1'b1, 1'b0);
                end
            end
            cpm_pkg::OP_RGB2XYZ:
            begin
                for (int k = 0; k < 3; k++)
                begin
                    if (y_zero)
                        push_row('0, '0, '0, k, k == 2, 1'b1);
                    else
                    begin
                        for (int r = 0; r < 3; r++)
                        begin
                            num = sc[k];
                            num = (num * abs64(p[r][k])) << 16;
                            den = ys[k];
                            den = den << 16;
                            c[r] = fixed_quotient(p[r][k] < 0, num, den);
                        end
                        push_row(c[0], c[1], c[2], k, k == 2, 1'b0);
                    end
                end
            end
            cpm_pkg::OP_XYZ2RGB:
            begin
                bad = y_zero;
                if (!bad)
                begin
                    // det(M) = det * prod(scale) / (2^48 * prod_y)
                    lhs = abs64(det);
                    lhs = lhs * sc[0] * sc[1] * sc[2];
                    num = prod_y;
                    if (lhs < (num << 6))
                        bad = 1'b1;
                end
                for (int k = 0; k < 3; k++)
                begin
                    if (bad)
                        push_row('0, '0, '0, k, k == 2, 1'b1);
                    else
                    begin
                        for (int r = 0; r < 3; r++)
                        begin
                            num = ys[r];
                            num = (num * abs64(adj[r][k])) << 32;
                            den = sc[r];
                            den = den * abs64(det);
                            c[r] = fixed_quotient((adj[r][k] < 0) != (det < 0), num, den);
                        end
                        push_row(c[0], c[1], c[2], k, k == 2, 1'b0);
                    end
                end
            end
            default:
                push_row('0, '0, '0, 0, 1'b1, 1'b1);
        endcase
    endfunction

    function automatic void queue_request(logic [1:0] op,
                                          int rx, int gx, int bx, int ry, int gy, int by,
                                          int wx, int wy, int rs, int gs, int bs);
        request_t q;
        int       f[11];
        f = '{rx, gx, bx, ry, gy, by, wx, wy, rs, gs, bs};
        q.op = op;
        for (int i = 0; i < 11; i++)
            q.data[16*i +: 16] = f[i][15:0];
        // a run of back-to-back transfers in the middle of the random part
        if (pending_reqs.size() >= 70 && pending_reqs.size() < 100)
            q.gap = 0;
        else
            q.gap = $urandom_range(0, 5);
        pending_reqs.push_back(q);
    endfunction

    // source: one transfer per request, idle gap drawn per request
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_wait <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_matrix_rows(s_tuser, s_tdata);
                n_accepted <= n_accepted + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_wait > 0)
                begin
                    send_wait <= send_wait - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_reqs.size() > 0)
                begin
                    request_t q;
                    q = pending_reqs.pop_front();
                    s_tuser <= q.op;
                    s_tdata <= q.data;
                    s_tvalid <= 1'b1;
                    send_wait <= q.gap;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // sink: check each row transfer, then hold off for a drawn number of cycles
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_wait <= 0;
        end
        else if (m_tvalid && m_tready)
        begin
            int                 w;
            row_result_t        e;
            logic [24:0]        g0;
            logic [24:0]        g1;
            logic [24:0]        g2;
            logic [1:0]         gr;
            g0 = m_tdata[24:0];
            g1 = m_tdata[49:25];
            g2 = m_tdata[74:50];
            gr = m_tdata[76:75];
            n_rows <= n_rows + 1;
            if (m_tuser)
                n_err_rows <= n_err_rows + 1;
            if (expected_rows.size() == 0)
            begin
                $error("unexpected row transfer: row_index %0d", gr);
                errors++;
            end
            else
            begin
                e = expected_rows.pop_front();
                if (g0 !== e.col0)
                begin
                    $error("col0 expected %0d got %0d", $signed(e.col0), $signed(g0));
                    errors++;
                end
                if (g1 !== e.col1)
                begin
                    $error("col1 expected %0d got %0d", $signed(e.col1), $signed(g1));
                    errors++;
                end
                if (g2 !== e.col2)
                begin
                    $error("col2 expected %0d got %0d", $signed(e.col2), $signed(g2));
                    errors++;
                end
                if (gr !== e.row)
                begin
                    $error("row_index expected %0d got %0d", e.row, gr);
                    errors++;
                end
                if (m_tlast !== e.last)
                begin
                    $error("last_row expected %0d got %0d", e.last, m_tlast);
                    errors++;
                end
                if (m_tuser !== e.err)
                begin
                    $error("error_flag expected %0d got %0d", e.err, m_tuser);
                    errors++;
                end
            end
            // long hold-off once so the pipe fills and stalls the input
            if (n_rows == 40)
                w = 300;
            else if (n_rows >= 150 && n_rows < 230)
                w = 0;
            else
                w = $urandom_range(0, 5);
            if (w == 0)
                m_tready <= 1'b1;
            else
            begin
                m_tready <= 1'b0;
                recv_wait <= w;
            end
        end
        else if (recv_wait > 0)
        begin
            recv_wait <= recv_wait - 1;
            if (recv_wait == 1)
                m_tready <= 1'b1;
        end
        else
            m_tready <= 1'b1;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[color_primaries_matrix_unit] ERROR");
            $finish;
        end
    end

    initial
    begin
        int kind;
        int v[11];
        logic [1:0] op;

        // directed: sRGB primaries with D65 white and sRGB luminances
        queue_request(cpm_pkg::OP_SCALES,  41943, 19661, 9830, 21627, 39322, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_RGB2XYZ, 41943, 19661, 9830, 21627, 39322, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_XYZ2RGB, 41943, 19661, 9830, 21627, 39322, 3932,
                      20493, 21561, 13933, 46871, 4732);
        // zero primary y, zero white y
        queue_request(cpm_pkg::OP_SCALES,  41943, 19661, 9830, 0, 39322, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_SCALES,  41943, 19661, 9830, 21627, 39322, 3932,
                      20493, 0, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_RGB2XYZ, 41943, 19661, 9830, 21627, 0, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_XYZ2RGB, 41943, 19661, 9830, 21627, 39322, 0,
                      20493, 21561, 13933, 46871, 4732);
        // singular: two identical primaries; zero scale
        queue_request(cpm_pkg::OP_SCALES,  20000, 20000, 9830, 30000, 30000, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_XYZ2RGB, 20000, 20000, 9830, 30000, 30000, 3932,
                      20493, 21561, 13933, 46871, 4732);
        queue_request(cpm_pkg::OP_XYZ2RGB, 41943, 19661, 9830, 21627, 39322, 3932,
                      20493, 21561, 13933, 0, 4732);
        // field extremes and saturation
        queue_request(cpm_pkg::OP_SCALES,  65535, 65535, 65535, 65535, 65535, 65535,
                      65535, 65535, 65535, 65535, 65535);
        queue_request(cpm_pkg::OP_RGB2XYZ, 65535, 65535, 65535, 1, 1, 1,
                      65535, 65535, 65535, 65535, 65535);
        queue_request(cpm_pkg::OP_XYZ2RGB, 41943, 19661, 9830, 21627, 39322, 3932,
                      0, 0, 1, 1, 1);
        queue_request(cpm_pkg::OP_SCALES,  0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        queue_request(cpm_pkg::OP_SCALES,  65535, 0, 1, 1, 65535, 1, 0, 1, 0, 0, 0);
        queue_request(cpm_pkg::OP_XYZ2RGB, 65535, 0, 0, 1, 65535, 1, 0, 0,
                      65535, 65535, 65535);
        queue_request(cpm_pkg::OP_NONE,    65535, 65535, 65535, 65535, 65535, 65535,
                      65535, 65535, 65535, 65535, 65535);
        queue_request(cpm_pkg::OP_NONE,    0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);

        // random: mostly plausible gamuts, some noise and degenerate sets
        for (int i = 0; i < N_RANDOM; i++)
        begin
            kind = $urandom_range(0, 9);
            op = 2'($urandom_range(0, 2));
            for (int j = 0; j < 11; j++)
                v[j] = $urandom_range(1000, 50000);
            unique case (kind)
                6:
                begin
                    op = 2'($urandom_range(0, 3));
                    for (int j = 0; j < 11; j++)
                        v[j] = $urandom_range(0, 65535);
                end
                7:
                    v[$urandom_range(3, 5)] = 0;
                8:
                begin
                    v[1] = v[0];
                    v[4] = v[3];
                end
                9:
                    for (int j = 8; j < 11; j++)
                        v[j] = $urandom_range(0, 40);
                default:
                    ;
            endcase
            queue_request(op, v[0], v[1], v[2], v[3], v[4], v[5],
                          v[6], v[7], v[8], v[9], v[10]);
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (pending_reqs.size() > 0 || s_tvalid || expected_rows.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d requests over all four op codes, %0d row transfers",
                 n_accepted, n_rows);
        $display("(%0d flagged as errors), with random idling and one long sink stall.",
                 n_err_rows);
        if (errors == 0)
            $display("[color_primaries_matrix_unit] OK");
        else
            $display("[color_primaries_matrix_unit] ERROR");
        $finish;
    end

endmodule

FILE: color_primaries_matrix_unit.f
hdl/cpm_pkg.sv
hdl/cpm_front.sv
hdl/cpm_lane.sv
hdl/color_primaries_matrix_unit.sv
verif/tb_top.sv
